// ===== src/pts_pkg.sv =====
// types, codes and command structs shared by the periodic timer slot table
`default_nettype none
package pts_pkg;

	localparam int PERIOD_W = 16;
	localparam int SLOT_W   = 8;
	localparam int ID_W     = 3;

	typedef enum logic [1:0] {
		REQ_REGISTER = 2'd0,
		REQ_REMOVE   = 2'd1,
		REQ_TICK     = 2'd2,
		REQ_UNUSED   = 2'd3
	} req_type_t;

	typedef enum logic {
		KIND_REPLY  = 1'b0,
		KIND_EXPIRY = 1'b1
	} kind_t;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [PERIOD_W-1:0] period;
		logic [SLOT_W-1:0]   slot;
	} req_t;

	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] slot_id;
		logic            full_res;
		logic            last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_SCAN,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic start_alloc;
		logic start_tick;
		logic remove;
		logic alloc;
		logic scan;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic free;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== src/periodic_timer_slot_table_top.sv =====
// top level of the periodic timer slot table
//
// a request is taken as one transaction when start is high and busy is low;
// req carries the request type, a period for register and a slot for remove
// results leave on res, each valid for exactly one cycle while strobe is high;
// the receiver cannot stall, so results are never held back
// register: scans slots from 1 upward one per cycle until a free slot or the last
//   slot; the reply (slot number or full flag) follows in the next cycle
// remove: done in the accepting cycle, busy never rises, no result
// tick: sweeps every slot through the period and count memories one slot per
//   cycle, then drains and flushes; expiries come out at most one per cycle
//   in ascending slot order, the final one with last set in the cycle busy falls
// unused request type: ignored, no result
// reset: all slots free, no result pending; the count memory is not cleared,
//   every slot's count is written when it is claimed
`default_nettype none
module periodic_timer_slot_table_top #(
	parameter int NUM_SLOTS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire pts_pkg::req_t req,
	output logic               busy,
	output logic               strobe,
	output pts_pkg::res_t      res
);
	import pts_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	pts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	pts_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.sts    (sts),
		.strobe (strobe),
		.res    (res)
	);

endmodule
`default_nettype wire

// ===== src/pts_ctrl.sv =====
// controller state machine sequencing allocation scans and tick sweeps
`default_nettype none
module pts_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       req_type,
	input  wire pts_pkg::dp_sts_t sts,
	output pts_pkg::dp_cmd_t      cmd,
	output logic                  busy
);
	import pts_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_type == REQ_REGISTER) begin
					state_d = ST_ALLOC;
				end else if (accept && req_type == REQ_TICK) begin
					state_d = ST_SCAN;
				end
			end
			ST_ALLOC: begin
				if (sts.free || sts.idx_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (sts.idx_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd         = '0;
		busy        = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy            = 1'b0;
				cmd.start_alloc = accept && (req_type == REQ_REGISTER);
				cmd.start_tick  = accept && (req_type == REQ_TICK);
				cmd.remove      = accept && (req_type == REQ_REMOVE);
			end
			ST_ALLOC: begin
				cmd.alloc = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_DRAIN: begin
				cmd.scan = 1'b0;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/pts_datapath.sv =====
// slot table storage, slot index counter, counter update and result register
`default_nettype none
module pts_datapath #(
	parameter int NUM_SLOTS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pts_pkg::dp_cmd_t cmd,
	input  wire pts_pkg::req_t    req,
	output pts_pkg::dp_sts_t      sts,
	output logic                  strobe,
	output pts_pkg::res_t         res
);
	import pts_pkg::*;

	localparam int SW = $clog2(NUM_SLOTS);
	localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

	logic [SW-1:0]       idx_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [PERIOD_W-1:0] per_q;
	logic [PERIOD_W-1:0] period_mem [NUM_SLOTS];
	logic [PERIOD_W-1:0] count_mem  [NUM_SLOTS];

	logic                valid_s1;
	logic [SW-1:0]       idx_s1;
	logic                act_s1;
	logic [PERIOD_W-1:0] period_s1;
	logic [PERIOD_W-1:0] count_s1;

	logic                pend_v_q;
	logic [SW-1:0]       pend_id_q;
	logic                strobe_q;
	res_t                res_q;

	logic                free;
	logic                idx_last;
	logic                claim;
	logic [PERIOD_W-1:0] cnt_inc;
	logic                expire;
	logic                cnt_we;
	logic [SW-1:0]       cnt_wa;
	logic [PERIOD_W-1:0] cnt_wd;
	logic                emit;
	res_t                res_d;

	assign free     = !active_q[idx_q];
	assign idx_last = (idx_q == LAST_IDX);
	assign claim    = cmd.alloc && free;
	assign cnt_inc  = count_s1 + PERIOD_W'(1);
	assign expire   = valid_s1 && act_s1 && (cnt_inc >= period_s1);
	assign cnt_we   = claim || (valid_s1 && act_s1);
	assign cnt_wa   = claim ? idx_q : idx_s1;
	assign cnt_wd   = (claim || expire) ? '0 : cnt_inc;

	assign sts.free     = free;
	assign sts.idx_last = idx_last;

	always_comb begin
		emit  = 1'b0;
		res_d = '0;
		priority if (cmd.alloc && (free || idx_last)) begin
			emit           = 1'b1;
			res_d.kind     = KIND_REPLY;
			res_d.slot_id  = free ? ID_W'(idx_q) : '0;
			res_d.full_res = !free;
			res_d.last     = 1'b1;
		end else if (expire && pend_v_q) begin
			emit          = 1'b1;
			res_d.kind    = KIND_EXPIRY;
			res_d.slot_id = ID_W'(pend_id_q);
		end else if (cmd.flush && pend_v_q) begin
			emit          = 1'b1;
			res_d.kind    = KIND_EXPIRY;
			res_d.slot_id = ID_W'(pend_id_q);
			res_d.last    = 1'b1;
		end else begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			active_q <= '0;
			valid_s1 <= 1'b0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.start_alloc) begin
				idx_q <= SW'(1);
			end else if (cmd.start_tick) begin
				idx_q <= '0;
			end else if ((cmd.alloc && !free && !idx_last) || (cmd.scan && !idx_last)) begin
				idx_q <= idx_q + SW'(1);
			end
			if (cmd.remove && (req.slot < SLOT_W'(NUM_SLOTS))) begin
				active_q[req.slot[SW-1:0]] <= 1'b0;
			end else if (claim) begin
				active_q[idx_q] <= 1'b1;
			end
			valid_s1 <= cmd.scan;
			if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end else if (expire) begin
				pend_v_q <= 1'b1;
			end
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_alloc) begin
			per_q <= req.period;
		end
		idx_s1 <= idx_q;
		act_s1 <= active_q[idx_q];
		if (expire) begin
			pend_id_q <= idx_s1;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			period_mem[idx_q] <= per_q;
		end
		period_s1 <= period_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[cnt_wa] <= cnt_wd;
		end
		count_s1 <= count_mem[idx_q];
	end

	assign strobe = strobe_q;
	assign res    = res_q;

endmodule
`default_nettype wire
